// ===== src/gss_pkg.sv =====
// shared constants, types and tables for the golden-section minimum search
package gss_pkg;

   localparam int unsigned MaxItersDefault    = 64;
   localparam int unsigned CordicStepsDefault = 24;
   localparam int unsigned FracBitsDefault    = 16;

   localparam logic [31:0] InvPhiQ32   = 32'h9E3779B9;
   localparam logic [31:0] TwoOverPi   = 32'hA2F9836E;
   localparam logic [33:0] CordicGain  = 34'h026DD3B6A;
   localparam logic [33:0] OneQ30      = 34'h040000000;

   // which probe a function evaluation belongs to
   typedef enum logic [2:0] {
      EV_INIT_LEFT,
      EV_INIT_RIGHT,
      EV_LEFT,
      EV_RIGHT,
      EV_MID
   } eval_mode_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_STEP  = 8'b0000_0010,
      ST_PROBE = 8'b0000_0100,
      ST_PHASE = 8'b0000_1000,
      ST_ROT   = 8'b0001_0000,
      ST_GDONE = 8'b0010_0000,
      ST_CHECK = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      logic [31:0] v;
      case (k)
         5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// ===== src/gss_if.sv =====
// request and response channel interfaces
interface gss_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] lower_bound;
   logic signed [31:0] upper_bound;
   logic        [30:0] tolerance;
   modport source (output valid, lower_bound, upper_bound, tolerance, input ready);
   modport sink   (input valid, lower_bound, upper_bound, tolerance, output ready);
endinterface

interface gss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_at_min;
   logic signed [17:0] y_at_min;
   logic        [30:0] half_width;
   logic        [6:0]  iterations_used;
   logic               hit_limit;
   modport source (output valid, x_at_min, y_at_min, half_width, iterations_used, hit_limit,
                   input ready);
   modport sink   (input valid, x_at_min, y_at_min, half_width, iterations_used, hit_limit,
                   output ready);
endinterface

// ===== src/gss_mul.sv =====
// shared signed 33x33 multiplier
module gss_mul (
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [65:0] product
);
   assign product = op_a * op_b;
endmodule

// ===== src/gss_cordic.sv =====
// iterative cordic rotation unit, one micro-rotation per cycle
module gss_cordic #(
   parameter int unsigned CORDIC_STEPS = gss_pkg::CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [29:0]        angle,
   output logic               done,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);
   import gss_pkg::*;

   localparam logic [4:0] LastIter = 5'(CORDIC_STEPS - 1);

   logic               busy_ff, busy_in;
   logic [4:0]         iter_ff, iter_in;
   logic signed [33:0] cx_ff, cx_in, sy_ff, sy_in;
   logic signed [32:0] z_ff, z_in;
   logic signed [33:0] dx, dy;
   logic signed [32:0] at;

   assign at   = $signed({1'b0, atan_turn(iter_ff)});
   assign dx   = sy_ff >>> iter_ff;
   assign dy   = cx_ff >>> iter_ff;
   assign done = busy_ff && (iter_ff == LastIter);

   always_comb begin
      busy_in = busy_ff;
      iter_in = iter_ff;
      cx_in   = cx_ff;
      sy_in   = sy_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         cx_in   = $signed(CordicGain);
         sy_in   = '0;
         z_in    = $signed({3'b000, angle});
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            cx_in = cx_ff - dx;
            sy_in = sy_ff + dy;
            z_in  = z_ff - at;
         end else begin
            cx_in = cx_ff + dx;
            sy_in = sy_ff - dy;
            z_in  = z_ff + at;
         end
         iter_in = iter_ff + 5'd1;
         if (iter_ff == LastIter) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
      cx_ff <= cx_in;
      sy_ff <= sy_in;
      z_ff  <= z_in;
   end

   assign cos_out = cx_ff;
   assign sin_out = sy_ff;
endmodule

// ===== src/golden_section_minimum_search.sv =====
// golden-section minimum search of f(x) = -cos(x/2) - 1, top level
//
// channel  dir  fields
// req      in   lower_bound, upper_bound, tolerance
// rsp      out  x_at_min, y_at_min, half_width, iterations_used, hit_limit
//
// transfer out follows two probe evaluations, one per narrowing step and one at the midpoint;
// the block returns to idle after transfer out and takes no new transfer in before that
// each evaluation is a phase multiply and a cordic rotation, one micro-rotation per cycle
// req.ready is high only while idle; the result waits in its register until taken
// synchronous active-high reset returns the sequencer to idle
module golden_section_minimum_search #(
   parameter int unsigned MAX_ITERS    = gss_pkg::MaxItersDefault,
   parameter int unsigned CORDIC_STEPS = gss_pkg::CordicStepsDefault,
   parameter int unsigned FRAC_BITS    = gss_pkg::FracBitsDefault
) (
   input logic    clock,
   input logic    reset,
   gss_req_if.sink   req,
   gss_rsp_if.source rsp
);
   import gss_pkg::*;

   localparam logic [6:0] IterCap = 7'(MAX_ITERS);

   state_type          state_ff, state_in;
   eval_mode_type      mode_ff, mode_in;
   logic signed [31:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [31:0] x1_ff, x1_in, x2_ff, x2_in, ex_ff, ex_in;
   logic        [31:0] limit_ff, limit_in, s_ff, s_in;
   logic        [33:0] g1_ff, g1_in, g2_ff, g2_in;
   logic        [1:0]  quad_ff, quad_in;
   logic        [6:0]  count_ff, count_in;
   logic signed [31:0] xo_ff, xo_in;
   logic        [17:0] yo_ff, yo_in;
   logic        [30:0] half_ff, half_in;
   logic               hit_ff, hit_in;

   // shared multiplier operands
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] product;
   logic        [64:0] rounded;
   logic        [31:0] len_w;
   logic signed [32:0] sum_w;

   // cordic handshake
   logic               cor_start, cor_done;
   logic signed [33:0] cor_cos, cor_sin, c_raw, c_clamp;
   logic        [33:0] g_w;
   logic        [34:0] y_wide;

   gss_mul u_mul (.op_a(mul_a), .op_b(mul_b), .product(product));

   gss_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .angle(product[FRAC_BITS+32:FRAC_BITS+3]),
      .done(cor_done), .cos_out(cor_cos), .sin_out(cor_sin));

   // interval length, zero when reversed or empty
   assign len_w   = (hi_ff > lo_ff) ? 32'(hi_ff - lo_ff) : 32'd0;
   assign rounded = product[64:0] + 65'h080000000;
   assign sum_w   = 33'(lo_ff) + 33'(hi_ff);

   // one multiplier: golden step while stepping, phase otherwise
   always_comb begin
      if (state_ff == ST_STEP) begin
         mul_a = $signed({1'b0, len_w});
         mul_b = $signed({1'b0, InvPhiQ32});
      end else begin
         mul_a = 33'(ex_ff);
         mul_b = $signed({1'b0, TwoOverPi});
      end
   end

   assign cor_start = (state_ff == ST_PHASE);

   // quadrant fold, clamp, g = 1 - cos and y = g - 2
   always_comb begin
      case (quad_ff)
         2'd0:    c_raw = cor_cos;
         2'd1:    c_raw = -cor_sin;
         2'd2:    c_raw = -cor_cos;
         default: c_raw = cor_sin;
      endcase
      if (c_raw > $signed(OneQ30))       c_clamp = $signed(OneQ30);
      else if (c_raw < -$signed(OneQ30)) c_clamp = -$signed(OneQ30);
      else                               c_clamp = c_raw;
      g_w    = 34'($signed(OneQ30) - c_clamp);
      y_wide = ((35'(g_w) + (35'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS))
               - (35'd2 << FRAC_BITS);
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      x1_in    = x1_ff;
      x2_in    = x2_ff;
      ex_in    = ex_ff;
      limit_in = limit_ff;
      s_in     = s_ff;
      g1_in    = g1_ff;
      g2_in    = g2_ff;
      quad_in  = quad_ff;
      count_in = count_ff;
      xo_in    = xo_ff;
      yo_in    = yo_ff;
      half_in  = half_ff;
      hit_in   = hit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               lo_in    = req.lower_bound;
               hi_in    = req.upper_bound;
               limit_in = {req.tolerance, 1'b0};
               count_in = '0;
               mode_in  = EV_INIT_LEFT;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            // s = round(len / phi)
            s_in     = rounded[63:32];
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            case (mode_ff)
               EV_INIT_LEFT: begin
                  if (hi_ff < lo_ff) begin
                     x1_in = lo_ff;
                     x2_in = lo_ff;
                     ex_in = lo_ff;
                  end else begin
                     x1_in = 32'(hi_ff - $signed(s_ff));
                     x2_in = 32'(lo_ff + $signed(s_ff));
                     ex_in = 32'(hi_ff - $signed(s_ff));
                  end
               end
               EV_RIGHT: begin
                  x2_in = 32'(lo_ff + $signed(s_ff));
                  ex_in = 32'(lo_ff + $signed(s_ff));
               end
               default: begin
                  x1_in = 32'(hi_ff - $signed(s_ff));
                  ex_in = 32'(hi_ff - $signed(s_ff));
               end
            endcase
            state_in = ST_PHASE;
         end
         ST_PHASE: begin
            // phase product is ready here; the cordic loads its angle now
            quad_in  = product[FRAC_BITS+34:FRAC_BITS+33];
            state_in = ST_ROT;
         end
         ST_ROT: begin
            if (cor_done) begin
               state_in = ST_GDONE;
            end
         end
         ST_GDONE: begin
            case (mode_ff)
               EV_INIT_LEFT: begin
                  g1_in    = g_w;
                  ex_in    = x2_ff;
                  mode_in  = EV_INIT_RIGHT;
                  state_in = ST_PHASE;
               end
               EV_INIT_RIGHT, EV_RIGHT: begin
                  g2_in    = g_w;
                  state_in = ST_CHECK;
               end
               EV_LEFT: begin
                  g1_in    = g_w;
                  state_in = ST_CHECK;
               end
               default: begin
                  yo_in    = y_wide[17:0];
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_CHECK: begin
            if ((len_w > limit_ff) && (count_ff < IterCap)) begin
               // keep the upper part when the left probe is not lower
               if (g1_ff >= g2_ff) begin
                  lo_in   = x1_ff;
                  x1_in   = x2_ff;
                  g1_in   = g2_ff;
                  mode_in = EV_RIGHT;
               end else begin
                  hi_in   = x2_ff;
                  x2_in   = x1_ff;
                  g2_in   = g1_ff;
                  mode_in = EV_LEFT;
               end
               count_in = count_ff + 7'd1;
               state_in = ST_STEP;
            end else begin
               hit_in   = (len_w > limit_ff);
               half_in  = len_w[31:1];
               ex_in    = sum_w[32:1];
               xo_in    = sum_w[32:1];
               mode_in  = EV_MID;
               state_in = ST_PHASE;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= EV_INIT_LEFT;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      x1_ff    <= x1_in;
      x2_ff    <= x2_in;
      ex_ff    <= ex_in;
      limit_ff <= limit_in;
      s_ff     <= s_in;
      g1_ff    <= g1_in;
      g2_ff    <= g2_in;
      quad_ff  <= quad_in;
      xo_ff    <= xo_in;
      yo_ff    <= yo_in;
      half_ff  <= half_in;
      hit_ff   <= hit_in;
   end

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = (state_ff == ST_OUT);
   assign rsp.x_at_min        = xo_ff;
   assign rsp.y_at_min        = $signed(yo_ff);
   assign rsp.half_width      = half_ff;
   assign rsp.iterations_used = count_ff;
   assign rsp.hit_limit       = hit_ff;

   // the cap flag only with the full step count
   a_hit_cap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.hit_limit |-> rsp.iterations_used == IterCap)
      else $error("hit_limit without reaching the cap");

   // never more narrowing steps than the cap
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IterCap)
      else $error("step count beyond cap");

   // the cordic finishes only while the sequencer waits on it
   a_cordic_wait: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> state_ff == ST_ROT)
      else $error("cordic done outside rotation wait");

   // no result is shown right after a request is taken
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !rsp.valid)
      else $error("result shown right after transfer in");
endmodule

// ===== sim/tb_golden_section_minimum_search.sv =====
// self-checking testbench for the golden-section minimum search
module tb_golden_section_minimum_search;

   // one search request, and below the result it should produce
   typedef struct {
      logic signed [31:0] lower;
      logic signed [31:0] upper;
      logic        [30:0] tol;
   } search_req_type;

   typedef struct {
      logic signed [31:0] x_min;
      logic signed [17:0] y_min;
      logic        [30:0] half;
      logic        [6:0]  iters;
      logic               capped;
   } search_rsp_type;

   localparam int unsigned NUM_RANDOM   = 300;
   localparam int unsigned ITER_CAP     = 64;
   localparam int unsigned ROT_STEPS    = 24;
   localparam longint      ONE_Q30      = 64'sd1 << 30;
   localparam longint      CYCLE_LIMIT  = 3000000;
   localparam int unsigned STALL_CYCLES = 5000;

   // cordic angle table in turns of 2^32, rounded
   localparam logic [31:0] ATAN_TURNS [ROT_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   logic clock;
   logic reset;

   gss_req_if req_ch ();
   gss_rsp_if rsp_ch ();

   golden_section_minimum_search i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   search_req_type pending_searches[$];
   search_rsp_type expected_minima[$];

   int unsigned total_items;
   int unsigned sent_count;
   int unsigned result_count;
   int unsigned capped_count;
   int unsigned reversed_count;
   int unsigned mismatch_count;
   longint      cycle_count;
   logic        req_taken;
   logic        stall_active;
   logic        stall_done;
   int unsigned stall_count;

   // 1 - cos(x/2) in Q30, via phase reduction and a cordic rotation
   function automatic longint cos_gap(input longint x);
      logic [63:0] prod;
      logic [31:0] phase;
      longint      cx, sy, z, c, dx, dy;
      prod  = 64'(x) * 64'hA2F9836E;
      phase = prod[50:19];
      z     = phase[29:0];
      cx    = 64'sh26DD3B6A;
      sy    = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = sy >>> i;
         dy = cx >>> i;
         if (z >= 0) begin
            cx -= dx; sy += dy; z -= ATAN_TURNS[i];
         end else begin
            cx += dx; sy -= dy; z += ATAN_TURNS[i];
         end
      end
      case (phase[31:30])
         2'd0:    c = cx;
         2'd1:    c = -sy;
         2'd2:    c = -cx;
         default: c = sy;
      endcase
      if (c > ONE_Q30) c = ONE_Q30;
      if (c < -ONE_Q30) c = -ONE_Q30;
      return ONE_Q30 - c;
   endfunction

   // len / phi, rounded to nearest
   function automatic longint golden_cut(input longint len);
      logic [63:0] p;
      p = 64'(len) * 64'h9E3779B9 + 64'h80000000;
      return longint'(p >> 32);
   endfunction

   function automatic search_rsp_type search_minimum(input search_req_type rq);
      search_rsp_type r;
      longint      a, b, lim, len, x1, x2, g1, g2, mid, gm;
      int unsigned n;
      a   = rq.lower;
      b   = rq.upper;
      lim = longint'(rq.tol) << 1;
      len = (b > a) ? b - a : 0;
      x1  = b - golden_cut(len);
      x2  = a + golden_cut(len);
      n   = 0;
      // reversed interval collapses both probes onto the start
      if (b < a) begin
         x1 = a;
         x2 = a;
      end
      g1 = cos_gap(x1);
      g2 = cos_gap(x2);
      while (len > lim && n < ITER_CAP) begin
         if (g1 >= g2) begin
            a  = x1;
            x1 = x2; g1 = g2;
            x2 = a + golden_cut(b - a);
            g2 = cos_gap(x2);
         end else begin
            b  = x2;
            x2 = x1; g2 = g1;
            x1 = b - golden_cut(b - a);
            g1 = cos_gap(x1);
         end
         n++;
         len = b - a;
      end
      mid      = (a + b) >>> 1;
      gm       = cos_gap(mid);
      r.x_min  = mid[31:0];
      r.y_min  = 18'(((gm + (64'sd1 << 13)) >>> 14) - (64'sd2 << 16));
      r.half   = 31'(len >> 1);
      r.iters  = 7'(n);
      r.capped = (len > lim);
      return r;
   endfunction

   function automatic search_req_type make_req(input logic [31:0] lo, input logic [31:0] hi,
                                               input logic [30:0] tol);
      search_req_type s;
      s.lower = lo;
      s.upper = hi;
      s.tol   = tol;
      return s;
   endfunction

   // idle rates per phase: receiver slow first, then sender slow, then full speed
   function automatic int unsigned send_idle_pct();
      if (sent_count < total_items / 3) return 7;
      if (sent_count < 2 * total_items / 3) return 49;
      return 0;
   endfunction

   function automatic int unsigned recv_idle_pct();
      if (sent_count < total_items / 3) return 49;
      if (sent_count < 2 * total_items / 3) return 7;
      return 0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // cycle counter and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_minima.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // request driver: fields change on the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (pending_searches.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
            search_req_type s;
            s = pending_searches.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.lower_bound <= s.lower;
            req_ch.upper_bound <= s.upper;
            req_ch.tolerance   <= s.tol;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response sink readiness, forced low during the long hold-off
   always @(negedge clock) begin
      if (stall_active) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
   end

   // long receiver hold-off once the traffic is at full speed, so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         stall_active <= 1'b0;
         stall_done   <= 1'b0;
         stall_count  <= 0;
      end else if (stall_active) begin
         stall_count <= stall_count + 1;
         if (stall_count == STALL_CYCLES) begin
            stall_active <= 1'b0;
            stall_done   <= 1'b1;
         end
      end else if (!stall_done && sent_count >= 2 * total_items / 3 + 5) begin
         stall_active <= 1'b1;
      end
   end

   // request monitor: predicts the result of each accepted transfer
   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         search_rsp_type e;
         e = search_minimum(make_req(req_ch.lower_bound, req_ch.upper_bound,
                                     req_ch.tolerance));
         expected_minima.push_back(e);
         sent_count <= sent_count + 1;
         if (e.capped) capped_count <= capped_count + 1;
         if (req_ch.upper_bound < req_ch.lower_bound) reversed_count <= reversed_count + 1;
      end
   end

   // response monitor: compares each transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         result_count <= result_count + 1;
         if (expected_minima.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected result x=%0d y=%0d", rsp_ch.x_at_min, rsp_ch.y_at_min);
         end else begin
            search_rsp_type e;
            e = expected_minima.pop_front();
            if (rsp_ch.x_at_min !== e.x_min || rsp_ch.y_at_min !== e.y_min ||
                rsp_ch.half_width !== e.half || rsp_ch.iterations_used !== e.iters ||
                rsp_ch.hit_limit !== e.capped) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("mismatch at result %0d:", result_count);
                  $display("  exp x=%0d y=%0d half=%0d iters=%0d cap=%0d",
                           e.x_min, e.y_min, e.half, e.iters, e.capped);
                  $display("  got x=%0d y=%0d half=%0d iters=%0d cap=%0d",
                           rsp_ch.x_at_min, rsp_ch.y_at_min, rsp_ch.half_width,
                           rsp_ch.iterations_used, rsp_ch.hit_limit);
               end
            end
         end
      end
   end

   initial begin
      logic [31:0] lo, len;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.lower_bound = '0;
      req_ch.upper_bound = '0;
      req_ch.tolerance   = '0;
      rsp_ch.ready       = 1'b0;
      req_taken          = 1'b0;
      cycle_count        = 0;
      sent_count         = 0;
      result_count       = 0;
      capped_count       = 0;
      reversed_count     = 0;
      mismatch_count     = 0;

      // directed: extremes, reversed interval, zero tolerance, degenerate intervals
      pending_searches.push_back(make_req(32'sd0, 32'sd0, 31'd1));
      pending_searches.push_back(make_req(32'h80000000, 32'h7FFFFFFF, 31'd1));
      pending_searches.push_back(make_req(32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF));
      pending_searches.push_back(make_req(32'h7FFFFFFF, 32'h80000000, 31'd1));
      pending_searches.push_back(make_req(32'sd100, -32'sd100, 31'd5));
      pending_searches.push_back(make_req(32'sd0, 32'sd1, 31'd0));
      pending_searches.push_back(make_req(-32'sd65536, 32'sd65536, 31'd0));
      pending_searches.push_back(make_req(-32'sd262144, 32'sd262144, 31'd64));
      pending_searches.push_back(make_req(32'sd0, 32'sd411775, 31'd16));
      pending_searches.push_back(make_req(32'h80000000, 32'h80000000, 31'd1));
      pending_searches.push_back(make_req(32'h7FFFFFFF, 32'h7FFFFFFF, 31'd1));
      pending_searches.push_back(make_req(32'h7FFF0000, 32'h7FFFFFFF, 31'd2));
      pending_searches.push_back(make_req(32'h80000000, 32'h80010000, 31'd2));
      pending_searches.push_back(make_req(-32'sd823550, -32'sd1000, 31'd256));
      pending_searches.push_back(make_req(32'sd0, 32'sd1000, 31'h7FFFFFFF));
      pending_searches.push_back(make_req(32'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA));
      pending_searches.push_back(make_req(32'hAAAAAAAA, 32'h55555555, 31'h55555555));

      // random: mostly well-formed intervals of moderate size
      for (int i = 0; i < NUM_RANDOM; i++) begin
         case ($urandom_range(9))
            0: pending_searches.push_back(make_req($urandom, $urandom, 31'($urandom)));
            6: begin
               lo  = $urandom;
               pending_searches.push_back(make_req(lo, lo - $urandom_range(1, 1 << 20),
                                                   31'($urandom)));
            end
            7: pending_searches.push_back(make_req(32'h80000000 + $urandom_range(0, 1 << 16),
                                                   32'h7FFFFFFF - $urandom_range(0, 1 << 16),
                                                   31'($urandom_range(1, 4))));
            8: begin
               lo  = $urandom_range(0, 1 << 25) - (1 << 24);
               len = $urandom_range(1, 1 << 16);
               pending_searches.push_back(make_req(lo, lo + len,
                                                   31'($urandom_range(len, 1 << 20))));
            end
            9: pending_searches.push_back(make_req($urandom, $urandom,
                                                   31'($urandom_range(1, 255))));
            default: begin
               lo  = $urandom_range(0, 1 << 25) - (1 << 24);
               len = $urandom_range(1, 1 << 22);
               pending_searches.push_back(make_req(lo, lo + len,
                                                   31'($urandom_range(1, 1 << 12))));
            end
         endcase
      end
      total_items = pending_searches.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent and every prediction checked
      while (pending_searches.size() != 0 || req_ch.valid || expected_minima.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      $display("%0d searches checked, %0d stopped by the iteration cap, %0d reversed",
               result_count, capped_count, reversed_count);
      $display("%0d mismatches over %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0 && expected_minima.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
